@@ hw/rtl/mqrf_pkg.sv @@
// Package for the multi-queue ring FIFO pool: default sizes, field widths,
// opcode and result codes, controller states and the controller/datapath structs.
// Depends on nothing; every other file of the block but mqrf_ram imports it.
package mqrf_pkg;

  // Default sizes for the top-level parameters.
  localparam int NUM_QUEUES_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int DATA_WIDTH_DEF  = 32;

  // Fixed widths of the transaction fields.
  localparam int OPCODE_W = 3;
  localparam int QID_W    = 3;
  localparam int SIZE_W   = 7;
  localparam int ITEM_W   = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;
  localparam int FREE_W   = 4;

  // Operation codes. The two unused codes behave as a status query.
  typedef enum logic [OPCODE_W-1:0] {
    OP_CREATE  = 3'd0,
    OP_DESTROY = 3'd1,
    OP_ENQUEUE = 3'd2,
    OP_DEQUEUE = 3'd3,
    OP_CLEAR   = 3'd4,
    OP_STATUS  = 3'd5
  } op_t;

  // Result codes.
  typedef enum logic [STATUS_W-1:0] {
    RES_OK        = 3'd0,
    RES_BAD_SIZE  = 3'd1,
    RES_NO_FREE   = 3'd2,
    RES_FULL      = 3'd3,
    RES_EMPTY     = 3'd4,
    RES_NULL_ITEM = 3'd5,
    RES_UNALLOC   = 3'd6
  } res_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_EXEC   = 2'd1,
    S_FINISH = 2'd2
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // latch the input transaction and read its descriptor
    logic commit;    // write back queue state and issue the entry store access
    logic load_out;  // load the result register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic deq_hit;   // the pending operation is a dequeue that succeeds
  } dp_stat_t;

endpackage

@@ hw/rtl/multi_queue_ring_fifo_pool.sv @@
// Top level of the multi-queue ring FIFO pool: controller plus datapath.
// Depends on mqrf_pkg, mqrf_ctrl, mqrf_dp (and mqrf_ram through the datapath).
//
//   Channel   Handshake             Payload
//   input     in_valid / in_stall   opcode, queue_id, queue_size, item_value
//   output    out_valid / out_stall status, new_queue_id, item_out,
//                                   entry_count, free_queues
//
// A transaction reads the queue descriptor RAM on accept in S_IDLE, then decides
// and writes back in S_EXEC; a successful dequeue then waits in S_FINISH for the
// registered read of the entry store. A held result delays the write-back of any operation but a successful dequeue.
// Synchronous active-high reset frees all queues; no clearing pass is needed.
// in_stall is high whenever a transaction is in progress.
module multi_queue_ring_fifo_pool
  import mqrf_pkg::*;
#(
  parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [QID_W-1:0]    queue_id,
  input  logic [SIZE_W-1:0]   queue_size,
  input  logic [ITEM_W-1:0]   item_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [QID_W-1:0]    new_queue_id,
  output logic [ITEM_W-1:0]   item_out,
  output logic [COUNT_W-1:0]  entry_count,
  output logic [FREE_W-1:0]   free_queues
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencing.
  mqrf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Queue state and storage.
  mqrf_dp #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .opcode       (opcode),
    .queue_id     (queue_id),
    .queue_size   (queue_size),
    .item_value   (item_value),
    .status       (status),
    .new_queue_id (new_queue_id),
    .item_out     (item_out),
    .entry_count  (entry_count),
    .free_queues  (free_queues)
  );

endmodule

@@ hw/rtl/mqrf_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module mqrf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/mqrf_ctrl.sv @@
// Controller of the multi-queue ring FIFO pool: sequences accept, commit and result load.
// Depends on mqrf_pkg.
module mqrf_ctrl
  import mqrf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;

  // The result register can take a new result when empty or being drained.
  assign out_free = !out_valid || !out_stall;

  // State and result-valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next   = state;
    cmd          = '0;
    in_stall     = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        // A successful dequeue commits at once and waits for the stored word.
        if (stat.deq_hit) begin
          cmd.commit = 1'b1;
          state_next = S_FINISH;
        end else if (out_free) begin
          cmd.commit   = 1'b1;
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // The result stays valid until the receiving side takes it.
  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

@@ hw/rtl/mqrf_dp.sv @@
// Datapath of the multi-queue ring FIFO pool: input and result registers, queue
// descriptors, allocation bits, free counter and the shared entry store.
// Depends on mqrf_pkg and mqrf_ram.
module mqrf_dp
  import mqrf_pkg::*;
#(
  parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [QID_W-1:0]    queue_id,
  input  logic [SIZE_W-1:0]   queue_size,
  input  logic [ITEM_W-1:0]   item_value,
  output logic [STATUS_W-1:0] status,
  output logic [QID_W-1:0]    new_queue_id,
  output logic [ITEM_W-1:0]   item_out,
  output logic [COUNT_W-1:0]  entry_count,
  output logic [FREE_W-1:0]   free_queues
);

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int FW = $clog2(NUM_QUEUES + 1);
  localparam int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH);
  localparam int DW = CW + PW + PW + CW;

  // Latched input transaction.
  logic [OPCODE_W-1:0]   op_r;
  logic [QID_W-1:0]      qid_r;
  logic [SIZE_W-1:0]     size_r;
  logic [DATA_WIDTH-1:0] item_r;

  // Queue bookkeeping.
  logic [NUM_QUEUES-1:0] allocated;
  logic [FW-1:0]         free_cnt;

  // Descriptor store and its fields.
  logic [DW-1:0]         desc_rd, desc_wd;
  logic [QW-1:0]         desc_waddr;
  logic                  desc_we;
  logic [CW-1:0]         cap, cnt;
  logic [PW-1:0]         rp, wp;

  // Entry store.
  logic [DATA_WIDTH-1:0] st_rd;
  logic [AW-1:0]         st_addr;
  logic                  st_we;

  // Decoded operation.
  logic [QW-1:0]         qidx;
  logic                  in_range, q_alloc;
  logic                  size_bad, item_zero;
  logic [NUM_QUEUES-1:0] free_vec, low_free;
  logic [QW-1:0]         new_id;
  logic [CW:0]           wp_inc, rp_inc;
  logic [PW-1:0]         wp_bump, rp_bump;
  logic [AW-1:0]         base;
  logic [STATUS_W-1:0]   status_c;
  logic [QW-1:0]         new_id_c;
  logic [CW-1:0]         cnt_after;
  logic [FW-1:0]         free_after;
  logic                  deq_hit, set_alloc, clr_alloc;

  assign {cap, rp, wp, cnt} = desc_rd;

  // Input register, loaded when a transaction is accepted.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= opcode;
      qid_r  <= queue_id;
      size_r <= queue_size;
      item_r <= DATA_WIDTH'(item_value);
    end
  end

  assign qidx     = QW'(qid_r);
  assign in_range = {29'd0, qid_r} < 32'(NUM_QUEUES);
  assign q_alloc  = in_range && allocated[qidx];

  assign size_bad  = (size_r == '0) || ({25'd0, size_r} > 32'(QUEUE_DEPTH));
  assign item_zero = (item_r == '0);

  // Lowest free queue: isolate the lowest set bit, then encode it.
  assign free_vec = ~allocated;
  assign low_free = free_vec & (~free_vec + NUM_QUEUES'(1));
  always_comb begin
    new_id = '0;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      if (low_free[i]) begin
        new_id = new_id | QW'(i);
      end
    end
  end

  // Ring pointer advance, wrapping at the queue's capacity.
  assign wp_inc  = (CW + 1)'(wp) + (CW + 1)'(1);
  assign rp_inc  = (CW + 1)'(rp) + (CW + 1)'(1);
  assign wp_bump = (wp_inc >= {1'b0, cap}) ? '0 : PW'(wp_inc);
  assign rp_bump = (rp_inc >= {1'b0, cap}) ? '0 : PW'(rp_inc);

  // Base of the addressed queue's region in the entry store.
  assign base = AW'(qidx) * AW'(QUEUE_DEPTH);

  // Outcome of the pending operation and the state it leaves.
  always_comb begin
    status_c   = RES_OK;
    new_id_c   = '0;
    cnt_after  = '0;
    desc_we    = 1'b0;
    desc_waddr = qidx;
    desc_wd    = desc_rd;
    st_we      = 1'b0;
    st_addr    = base + AW'(rp);
    deq_hit    = 1'b0;
    set_alloc  = 1'b0;
    clr_alloc  = 1'b0;
    if (op_r == OP_CREATE) begin
      if (size_bad) begin
        status_c = RES_BAD_SIZE;
      end else if (free_cnt == '0) begin
        status_c = RES_NO_FREE;
      end else begin
        new_id_c   = new_id;
        set_alloc  = 1'b1;
        desc_we    = 1'b1;
        desc_waddr = new_id;
        desc_wd    = {CW'(size_r), PW'(0), PW'(0), CW'(0)};
      end
    end else if (!q_alloc) begin
      status_c = RES_UNALLOC;
    end else begin
      case (op_r)
        OP_DESTROY: begin
          clr_alloc = 1'b1;
        end
        OP_ENQUEUE: begin
          cnt_after = cnt;
          if (item_zero) begin
            status_c = RES_NULL_ITEM;
          end else if (cnt >= cap) begin
            status_c = RES_FULL;
          end else begin
            st_we     = 1'b1;
            st_addr   = base + AW'(wp);
            desc_we   = 1'b1;
            desc_wd   = {cap, rp, wp_bump, cnt + CW'(1)};
            cnt_after = cnt + CW'(1);
          end
        end
        OP_DEQUEUE: begin
          cnt_after = cnt;
          if (cnt == '0) begin
            status_c = RES_EMPTY;
          end else begin
            deq_hit   = 1'b1;
            desc_we   = 1'b1;
            desc_wd   = {cap, rp_bump, wp, cnt - CW'(1)};
            cnt_after = cnt - CW'(1);
          end
        end
        OP_CLEAR: begin
          desc_we = 1'b1;
          desc_wd = {cap, PW'(0), PW'(0), CW'(0)};
        end
        default: begin
          cnt_after = cnt;
        end
      endcase
    end
  end

  assign stat.deq_hit = deq_hit;

  always_comb begin
    if (set_alloc) begin
      free_after = free_cnt - FW'(1);
    end else if (clr_alloc) begin
      free_after = free_cnt + FW'(1);
    end else begin
      free_after = free_cnt;
    end
  end

  // Allocation bits and free counter, updated at commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      allocated <= '0;
      free_cnt  <= FW'(NUM_QUEUES);
    end else if (cmd.commit) begin
      if (set_alloc) begin
        allocated[new_id] <= 1'b1;
      end
      if (clr_alloc) begin
        allocated[qidx] <= 1'b0;
      end
      free_cnt <= free_after;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status       <= status_c;
      new_queue_id <= QID_W'(new_id_c);
      item_out     <= deq_hit ? ITEM_W'(st_rd) : '0;
      entry_count  <= COUNT_W'(cnt_after);
      free_queues  <= FREE_W'(free_after);
    end
  end

  // Queue descriptors: capacity, read pointer, write pointer, fill count.
  mqrf_ram #(
    .WIDTH (DW),
    .DEPTH (NUM_QUEUES)
  ) u_desc_ram (
    .clk   (clk),
    .we    (cmd.commit && desc_we),
    .waddr (desc_waddr),
    .wdata (desc_wd),
    .re    (cmd.accept),
    .raddr (QW'(queue_id)),
    .rdata (desc_rd)
  );

  // Shared entry store, one region of QUEUE_DEPTH words per queue.
  mqrf_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (NUM_QUEUES * QUEUE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (cmd.commit && st_we),
    .waddr (st_addr),
    .wdata (item_r),
    .re    (cmd.commit && deq_hit),
    .raddr (st_addr),
    .rdata (st_rd)
  );

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the multi-queue ring FIFO pool.
// Depends on mqrf_pkg and multi_queue_ring_fifo_pool; it carries its own
// predictor of the pool and checks every result against it.
`timescale 1ns / 100ps

module testbench;
  import mqrf_pkg::*;

  localparam int NUM_Q        = NUM_QUEUES_DEF;
  localparam int DEPTH        = QUEUE_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1500;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 12;

  // The two undefined opcodes, which the pool treats as a status query.
  localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [QID_W-1:0]    new_id;
    logic [ITEM_W-1:0]   word;
    logic [COUNT_W-1:0]  count;
    logic [FREE_W-1:0]   free;
  } pool_result_t;

  logic                clk;
  logic                rst        = 1'b1;
  logic                in_valid   = 1'b0;
  logic                in_stall;
  logic [OPCODE_W-1:0] opcode     = '0;
  logic [QID_W-1:0]    queue_id   = '0;
  logic [SIZE_W-1:0]   queue_size = '0;
  logic [ITEM_W-1:0]   item_value = '0;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [QID_W-1:0]    new_queue_id;
  logic [ITEM_W-1:0]   item_out;
  logic [COUNT_W-1:0]  entry_count;
  logic [FREE_W-1:0]   free_queues;

  multi_queue_ring_fifo_pool uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .queue_id     (queue_id),
    .queue_size   (queue_size),
    .item_value   (item_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .new_queue_id (new_queue_id),
    .item_out     (item_out),
    .entry_count  (entry_count),
    .free_queues  (free_queues)
  );

  // Shadow state of the pool.
  logic               q_live  [NUM_Q];
  logic [COUNT_W-1:0] q_cap   [NUM_Q];
  logic [5:0]         q_rd    [NUM_Q];
  logic [5:0]         q_wr    [NUM_Q];
  logic [COUNT_W-1:0] q_fill  [NUM_Q];
  logic [ITEM_W-1:0]  ring_store [NUM_Q*DEPTH];

  pool_result_t pending_results[$];
  pool_result_t want;
  int errors          = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int status_hits [8];
  int burst_left      = 0;
  int idle_cycles     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < NUM_Q; i++) begin
      q_live[i] = 1'b0;
      q_cap[i]  = '0;
      q_rd[i]   = '0;
      q_wr[i]   = '0;
      q_fill[i] = '0;
    end
    for (int i = 0; i < 8; i++) status_hits[i] = 0;
  end

  // Applies one transaction to the shadow state and returns its result.
  function automatic pool_result_t pool_apply(logic [OPCODE_W-1:0] op, logic [QID_W-1:0] qid,
                                              logic [SIZE_W-1:0] size, logic [ITEM_W-1:0] word);
    pool_result_t r;
    logic [COUNT_W-1:0] nxt;
    logic [FREE_W-1:0]  nfree;
    logic               found;
    r = '0;
    found = 1'b0;
    if (op == OP_CREATE) begin
      if (size == 0 || size > DEPTH) begin
        r.status = RES_BAD_SIZE;
      end else begin
        r.status = RES_NO_FREE;
        for (int i = 0; i < NUM_Q; i++) begin
          if (!q_live[i] && !found) begin
            found     = 1'b1;
            q_live[i] = 1'b1;
            q_cap[i]  = size;
            q_rd[i]   = '0;
            q_wr[i]   = '0;
            q_fill[i] = '0;
            r.new_id  = i[QID_W-1:0];
            r.status  = RES_OK;
          end
        end
      end
    end else if (!q_live[qid]) begin
      r.status = RES_UNALLOC;
    end else begin
      case (op)
        OP_DESTROY, OP_CLEAR: begin
          if (op == OP_DESTROY) q_live[qid] = 1'b0;
          q_rd[qid]   = '0;
          q_wr[qid]   = '0;
          q_fill[qid] = '0;
        end
        OP_ENQUEUE: begin
          if (word == '0) begin
            r.status = RES_NULL_ITEM;
          end else if (q_fill[qid] >= q_cap[qid]) begin
            r.status = RES_FULL;
          end else begin
            ring_store[qid*DEPTH + q_wr[qid]] = word;
            nxt = {1'b0, q_wr[qid]} + 7'd1;
            q_wr[qid]   = (nxt >= q_cap[qid]) ? 6'd0 : nxt[5:0];
            q_fill[qid] = q_fill[qid] + 7'd1;
          end
        end
        OP_DEQUEUE: begin
          if (q_fill[qid] == '0) begin
            r.status = RES_EMPTY;
          end else begin
            r.word = ring_store[qid*DEPTH + q_rd[qid]];
            nxt = {1'b0, q_rd[qid]} + 7'd1;
            q_rd[qid]   = (nxt >= q_cap[qid]) ? 6'd0 : nxt[5:0];
            q_fill[qid] = q_fill[qid] - 7'd1;
          end
        end
        default: begin
          // Status and the undefined opcodes leave the queue alone.
        end
      endcase
    end
    if (op != OP_CREATE && q_live[qid]) r.count = q_fill[qid];
    nfree = '0;
    for (int i = 0; i < NUM_Q; i++) if (!q_live[i]) nfree = nfree + 4'd1;
    r.free = nfree;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
    errors++;
  endtask

  // Drives one transaction, idling first when the current burst is used up,
  // and records its predicted result once the pool accepts it.
  task automatic send_op(logic [OPCODE_W-1:0] op, logic [QID_W-1:0] qid,
                         logic [SIZE_W-1:0] size, logic [ITEM_W-1:0] word);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    in_valid   <= 1'b1;
    opcode     <= op;
    queue_id   <= qid;
    queue_size <= size;
    item_value <= word;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(pool_apply(op, qid, size, word));
    items_sent++;
  endtask

  // Compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, status", 32'(status), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report_mismatch("status", 32'(status), 32'(want.status));
        if (new_queue_id !== want.new_id)
          report_mismatch("new_queue_id", 32'(new_queue_id), 32'(want.new_id));
        if (item_out !== want.word) report_mismatch("item_out", item_out, want.word);
        if (entry_count !== want.count)
          report_mismatch("entry_count", 32'(entry_count), 32'(want.count));
        if (free_queues !== want.free)
          report_mismatch("free_queues", 32'(free_queues), 32'(want.free));
        status_hits[want.status]++;
        results_checked++;
      end
    end
  end

  // Receiver back-pressure: modes of random length, from none to heavy.
  int stall_mode = 0;
  int stall_mode_left = 0;
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_mode_left == 0) begin
        stall_mode      = $urandom_range(0, 3);
        stall_mode_left = $urandom_range(20, 200);
      end
      stall_mode_left--;
      stall_phase = (stall_phase + 1) % 7;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 99) < 30);
        2:       out_stall <= ($urandom_range(0, 99) < 70);
        default: out_stall <= (stall_phase < 3);
      endcase
    end
  end

  // Watchdog on cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("** multi_queue_ring_fifo_pool: FAILED **");
        $finish;
      end
    end
  end

  // Size checks, allocation of every queue, and create with none free.
  task automatic test_create_limits();
    send_op(OP_CREATE, QID_W'($urandom_range(0, 7)), 7'd0, $urandom);
    send_op(OP_CREATE, QID_W'($urandom_range(0, 7)), 7'd65, $urandom);
    send_op(OP_CREATE, QID_W'($urandom_range(0, 7)), 7'd127, $urandom);
    send_op(OP_CREATE, QID_W'($urandom_range(0, 7)), 7'd1, $urandom);
    send_op(OP_CREATE, QID_W'($urandom_range(0, 7)), 7'd64, $urandom);
    for (int s = 2; s < NUM_Q; s++)
      send_op(OP_CREATE, QID_W'($urandom_range(0, 7)), SIZE_W'(s), $urandom);
    send_op(OP_CREATE, QID_W'($urandom_range(0, 7)), 7'd3, $urandom);
  endtask

  // Null item, full and empty on the one-entry queue.
  task automatic test_queue_limits();
    send_op(OP_ENQUEUE, 3'd0, SIZE_W'($urandom_range(0, 127)), 32'h0);
    send_op(OP_ENQUEUE, 3'd0, SIZE_W'($urandom_range(0, 127)), 32'hFFFF_FFFF);
    send_op(OP_ENQUEUE, 3'd0, SIZE_W'($urandom_range(0, 127)), 32'h1);
    send_op(OP_DEQUEUE, 3'd0, SIZE_W'($urandom_range(0, 127)), $urandom);
    send_op(OP_DEQUEUE, 3'd0, SIZE_W'($urandom_range(0, 127)), $urandom);
    send_op(OP_ENQUEUE, 3'd1, SIZE_W'($urandom_range(0, 127)), 32'h1);
  endtask

  // Status query, the undefined opcodes, and clear.
  task automatic test_query_ops();
    send_op(OP_STATUS, 3'd1, SIZE_W'($urandom_range(0, 127)), $urandom);
    send_op(OP_SPARE_LO, 3'd1, SIZE_W'($urandom_range(0, 127)), $urandom);
    send_op(OP_SPARE_HI, 3'd0, SIZE_W'($urandom_range(0, 127)), $urandom);
    send_op(OP_CLEAR, 3'd1, SIZE_W'($urandom_range(0, 127)), $urandom);
  endtask

  // Destroy, then every operation on the freed queue.
  task automatic test_unallocated();
    send_op(OP_DESTROY, 3'd2, SIZE_W'($urandom_range(0, 127)), $urandom);
    send_op(OP_ENQUEUE, 3'd2, SIZE_W'($urandom_range(0, 127)), $urandom | 32'h1);
    send_op(OP_DEQUEUE, 3'd2, SIZE_W'($urandom_range(0, 127)), $urandom);
    send_op(OP_CLEAR, 3'd2, SIZE_W'($urandom_range(0, 127)), $urandom);
    send_op(OP_STATUS, 3'd2, SIZE_W'($urandom_range(0, 127)), $urandom);
    send_op(OP_DESTROY, 3'd2, SIZE_W'($urandom_range(0, 127)), $urandom);
  endtask

  // Mostly well-formed traffic on live queues, with phases that favor
  // filling or draining, and some noise on any field.
  task automatic test_random_traffic(int n_items);
    logic [OPCODE_W-1:0] op;
    logic [QID_W-1:0]    qid;
    logic [SIZE_W-1:0]   size;
    logic [ITEM_W-1:0]   word;
    int live_ids[$];
    int pick;
    int enq_bias;
    enq_bias = 75;
    for (int n = 0; n < n_items; n++) begin
      if (n % 64 == 63) enq_bias = (enq_bias == 75) ? 30 : 75;
      live_ids.delete();
      for (int i = 0; i < NUM_Q; i++) if (q_live[i]) live_ids.push_back(i);
      pick = $urandom_range(0, 99);
      size = SIZE_W'($urandom_range(0, 127));
      word = $urandom;
      qid  = (live_ids.size() != 0)
             ? QID_W'(live_ids[$urandom_range(0, live_ids.size() - 1)])
             : QID_W'($urandom_range(0, 7));
      if (live_ids.size() == 0 || pick < 8) begin
        op = OP_CREATE;
        pick = $urandom_range(0, 99);
        if (pick < 5) size = ($urandom_range(0, 1) != 0) ? 7'd0
                                                          : SIZE_W'($urandom_range(65, 127));
        else if (pick < 15) size = SIZE_W'($urandom_range(1, DEPTH));
        else size = SIZE_W'($urandom_range(1, 8));
      end else if (pick < 12) begin
        op = OP_DESTROY;
      end else if (pick < 15) begin
        op = OP_CLEAR;
      end else if (pick < 19) begin
        case ($urandom_range(0, 2))
          0:       op = OP_STATUS;
          1:       op = OP_SPARE_LO;
          default: op = OP_SPARE_HI;
        endcase
      end else if (pick < 24) begin
        op  = OPCODE_W'($urandom_range(0, 7));
        qid = QID_W'($urandom_range(0, 7));
      end else begin
        op = ($urandom_range(0, 99) < enq_bias) ? OP_ENQUEUE : OP_DEQUEUE;
        if ($urandom_range(0, 99) < 4) word = '0;
      end
      send_op(op, qid, size, word);
    end
  endtask

  // Drains the pool, prints what was covered and the verdict.
  task automatic finish_run();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d transactions and checked %0d results.", items_sent, results_checked);
    $display({"Outcomes: %0d ok, %0d bad size, %0d no free queue, %0d full, ",
              "%0d empty, %0d null, %0d unallocated."},
             status_hits[RES_OK], status_hits[RES_BAD_SIZE], status_hits[RES_NO_FREE],
             status_hits[RES_FULL], status_hits[RES_EMPTY], status_hits[RES_NULL_ITEM],
             status_hits[RES_UNALLOC]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("** multi_queue_ring_fifo_pool: PASSED **");
    end else begin
      $display("** multi_queue_ring_fifo_pool: FAILED **");
    end
    $finish;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_create_limits();
    test_queue_limits();
    test_query_ops();
    test_unallocated();
    test_random_traffic(RANDOM_ITEMS);
    finish_run();
  end

endmodule

@@ filelist.f @@
hw/rtl/mqrf_pkg.sv
hw/rtl/mqrf_ram.sv
hw/rtl/mqrf_ctrl.sv
hw/rtl/mqrf_dp.sv
hw/rtl/multi_queue_ring_fifo_pool.sv
verif/testbench.sv
